// ----- rtl/clcd_pkg.sv -----
// Shared types, codes and the init sequence table for the character LCD
// 4-bit bus sequencer. No dependencies; every other file imports it.
package clcd_pkg;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_MOVE  = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    localparam logic [1:0] CFG_ENABLE_PULSE = 2'd0;
    localparam logic [1:0] CFG_POWERON_WAIT = 2'd1;

    localparam logic [7:0] POWERON_WAIT_RST = 8'd50;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;

    // Last sequence step of an init request and of a single byte.
    localparam logic [3:0] INIT_LAST_STEP = 4'd14;
    localparam logic [3:0] BYTE_LAST_STEP = 4'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        t_op         opcode;
        logic [7:0]  char_code;
        logic [5:0]  column;
        logic [2:0]  line_index;
    } t_lcd_req;

    typedef struct packed {
        logic        event_kind;
        logic        reg_select;
        logic [3:0]  nibble;
        logic [7:0]  wait_ms;
        logic        last;
    } t_lcd_evt;

    // Classified request as it travels from the front to the back.
    typedef struct packed {
        logic        is_init;
        logic        rs;
        logic [7:0]  byte_val;
        logic        wait_one;
    } t_lcd_cmd;

    function automatic logic [7:0] row_base(input logic [2:0] row);
        logic [7:0] base;
        case (row)
            3'd0:    base = 8'h00;
            3'd1:    base = 8'h40;
            3'd2:    base = 8'h14;
            default: base = 8'h54;
        endcase
        return base;
    endfunction

    // Init sequence. Step zero is the all-pins-low event; its wait comes
    // from the configuration register and is filled in by the sequencer.
    function automatic t_lcd_evt init_evt(input logic [3:0] step);
        t_lcd_evt e;
        e = '{event_kind: 1'b1, reg_select: 1'b0, nibble: 4'h0,
              wait_ms: 8'd0, last: 1'b0};
        case (step)
            4'd0:  e.event_kind = 1'b0;
            4'd1:  begin e.nibble = 4'h3; e.wait_ms = 8'd5; end
            4'd2:  begin e.nibble = 4'h3; e.wait_ms = 8'd1; end
            4'd3:  begin e.nibble = 4'h3; e.wait_ms = 8'd1; end
            4'd4:  begin e.nibble = 4'h2; e.wait_ms = 8'd1; end
            4'd5:  e.nibble = 4'h2;
            4'd6:  begin e.nibble = 4'h8; e.wait_ms = 8'd1; end
            4'd7:  e.nibble = 4'h0;
            4'd8:  begin e.nibble = 4'h8; e.wait_ms = 8'd1; end
            4'd9:  e.nibble = 4'h0;
            4'd10: begin e.nibble = 4'h1; e.wait_ms = 8'd2; end
            4'd11: e.nibble = 4'h0;
            4'd12: begin e.nibble = 4'h6; e.wait_ms = 8'd1; end
            4'd13: e.nibble = 4'h0;
            4'd14: begin e.nibble = 4'hC; e.wait_ms = 8'd10; e.last = 1'b1; end
            default: e.event_kind = 1'b0;
        endcase
        return e;
    endfunction

endpackage

// ----- rtl/clcd_front.sv -----
// Front stage: accepts requests, classifies them into a byte command and
// holds one in a register until the queue takes it. Depends on clcd_pkg.
module clcd_front import clcd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_lcd_req  i_req,
    output logic      o_cmd_valid,
    input  logic      i_cmd_ready,
    output t_lcd_cmd  o_cmd
);

    logic     r_valid, n_valid;
    t_lcd_cmd r_cmd;
    t_lcd_cmd cls;
    logic [7:0] addr;

    assign addr = {2'b00, i_req.column} + row_base(i_req.line_index);

    always_comb begin
        cls = '{is_init: 1'b0, rs: 1'b0, byte_val: CMD_CLEAR, wait_one: 1'b0};
        case (i_req.opcode)
            OP_INIT:  cls.is_init = 1'b1;
            OP_CLEAR: cls.wait_one = 1'b1;
            OP_MOVE:  cls.byte_val = CMD_SET_DDRAM | addr;
            OP_WRITE: begin
                cls.rs       = 1'b1;
                cls.byte_val = i_req.char_code;
            end
            default:  cls.is_init = 1'b1;
        endcase
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= cls;
        end
    end

endmodule

// ----- rtl/clcd_queue.sv -----
// Short command queue between the front and the sequencer so that each
// side can stall on its own. Depends on clcd_pkg.
module clcd_queue import clcd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_lcd_cmd  i_data,
    output logic      o_ready,
    input  logic      i_pop,
    output logic      o_valid,
    output t_lcd_cmd  o_data
);

    t_lcd_cmd            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                push_ok, pop_ok;

    assign o_ready = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (pop_ok) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/clcd_back.sv -----
// Sequencer: plays each queued command out as bus events into an output register,
// one per cycle unless the receiver stalls. Depends on clcd_pkg.
module clcd_back import clcd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [7:0] i_poweron_wait,
    input  logic      i_cmd_valid,
    input  t_lcd_cmd  i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_lcd_evt  o_evt
);

    logic [3:0] r_step, n_step;
    logic       r_out_valid;
    t_lcd_evt   r_out;
    t_lcd_evt   evt;
    logic       ld;

    always_comb begin
        if (i_cmd.is_init) begin
            evt = init_evt(r_step);
            if (r_step == '0) begin
                evt.wait_ms = i_poweron_wait;
            end
        end else begin
            evt.event_kind = 1'b1;
            evt.reg_select = i_cmd.rs;
            evt.last       = r_step == BYTE_LAST_STEP;
            if (evt.last) begin
                evt.nibble  = i_cmd.byte_val[3:0];
                evt.wait_ms = {7'd0, i_cmd.wait_one};
            end else begin
                evt.nibble  = i_cmd.byte_val[7:4];
                evt.wait_ms = 8'd0;
            end
        end
    end

    assign ld      = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_pop   = ld && evt.last;
    assign o_valid = r_out_valid;
    assign o_evt   = r_out;

    always_comb begin
        n_step = r_step;
        if (ld) begin
            n_step = evt.last ? 4'd0 : r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out <= evt;
        end
    end

    // The step counter never runs past the end of the command it serves.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> (r_step <= (i_cmd.is_init ? INIT_LAST_STEP : BYTE_LAST_STEP)))
        else $error("sequencer step beyond end of command");

    // A command leaves the queue exactly when its last event is loaded.
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid && r_out.last && r_step == '0))
        else $error("command popped without loading its last event");

    // The sequencer is never part way through a command while the queue is empty.
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != '0) |-> i_cmd_valid)
        else $error("sequencer mid-command with empty queue");

endmodule

// ----- rtl/char_lcd_4bit_sequencer.sv -----
// Character LCD 4-bit bus sequencer. A request (init, clear, cursor move
// or character write) is accepted whenever the front register can move on,
// back to back while the command queue has room. Each request is played out
// as bus events at one event per cycle while the receiver does not stall.
// Init is played out as 15 events and every other request as 2. The rate
// is set by the back sequencer, which emits one event per clock into the
// output register when not stalled. A two-entry command queue lets requests
// be taken while events of earlier ones are still waiting. With the queue
// empty and the sequencer idle, a request passes the front register and the
// queue before its first event is loaded into the output register. A write
// to the enable pulse width index is accepted on the configuration port, but
// it is stored nowhere and changes no event field. Depends on clcd_pkg and
// the clcd_front, clcd_queue and clcd_back modules.
module char_lcd_4bit_sequencer import clcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_lcd_req   i_req,
    output logic       o_valid,
    input  logic       i_ready,
    output t_lcd_evt   o_evt,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    logic       poweron_we;
    logic [7:0] r_poweron_ms;
    logic       f_valid, f_ready;
    t_lcd_cmd   f_cmd;
    logic       q_valid, q_pop;
    t_lcd_cmd   q_cmd;

    // Only the power-on wait reaches the event stream.
    assign poweron_we = i_cfg_we && (i_cfg_idx == CFG_POWERON_WAIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poweron_ms <= POWERON_WAIT_RST;
        end else if (poweron_we) begin
            r_poweron_ms <= i_cfg_data;
        end
    end

    clcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    clcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_cmd),
        .o_ready (f_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    clcd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_poweron_wait (r_poweron_ms),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_cmd),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_evt          (o_evt)
    );

endmodule

// ----- sim/lcd_bus_event_checker.sv -----
// Bus event checker for the character LCD 4-bit sequencer: predicts the events of
// every accepted request and compares each accepted event with the oldest prediction.
// Depends on clcd_pkg for the request and event structs and the register indexes.
module lcd_bus_event_checker import clcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_lcd_req    i_req,
    input  logic        i_evt_valid,
    input  logic        i_evt_ready,
    input  t_lcd_evt    i_evt,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output int unsigned o_mismatches,
    output int unsigned o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] ENABLE_PULSE_RST = 4'd1;

    localparam logic [3:0] WAKE_NIBBLE [4] = '{4'h3, 4'h3, 4'h3, 4'h2};
    localparam logic [7:0] WAKE_WAIT   [4] = '{8'd5, 8'd1, 8'd1, 8'd1};
    localparam logic [7:0] SETUP_CMD   [5] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
    localparam logic [7:0] SETUP_WAIT  [5] = '{8'd1, 8'd1, 8'd2, 8'd1, 8'd10};
    localparam logic [7:0] ROW_OFFSET  [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    // The pulse width never shows up in an event; the copy only tracks the register.
    logic [3:0]  enable_pulse_ms = ENABLE_PULSE_RST;
    logic [7:0]  poweron_wait_ms = POWERON_WAIT_RST;
    t_lcd_evt    expected_events[$];
    int unsigned mismatch_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic t_lcd_evt bus_event(input logic kind, input logic rs,
                                           input logic [3:0] nib,
                                           input logic [7:0] wait_val);
        t_lcd_evt e;
        e.event_kind = kind;
        e.reg_select = rs;
        e.nibble     = nib;
        e.wait_ms    = wait_val;
        e.last       = 1'b0;
        return e;
    endfunction

    // A byte goes out high nibble first; only the second strobe carries the delay.
    task automatic queue_byte(input logic rs, input logic [7:0] value,
                              input logic [7:0] wait_val);
        expected_events.push_back(bus_event(1'b1, rs, value[7:4], 8'd0));
        expected_events.push_back(bus_event(1'b1, rs, value[3:0], wait_val));
    endtask

    task automatic queue_bus_events(input t_lcd_req req);
        logic [2:0] row;
        logic [7:0] ddram_addr;
        t_lcd_evt   final_evt;
        case (req.opcode)
            OP_INIT: begin
                expected_events.push_back(bus_event(1'b0, 1'b0, 4'h0, poweron_wait_ms));
                for (int i = 0; i < 4; i++) begin
                    expected_events.push_back(bus_event(1'b1, 1'b0, WAKE_NIBBLE[i],
                                                        WAKE_WAIT[i]));
                end
                for (int i = 0; i < 5; i++) begin
                    queue_byte(1'b0, SETUP_CMD[i], SETUP_WAIT[i]);
                end
            end
            OP_CLEAR: queue_byte(1'b0, CMD_CLEAR, 8'd1);
            OP_MOVE: begin
                row = (req.line_index > 3'd3) ? 3'd3 : req.line_index;
                ddram_addr = {2'b00, req.column} + ROW_OFFSET[row[1:0]];
                queue_byte(1'b0, CMD_SET_DDRAM | ddram_addr, 8'd0);
            end
            default: queue_byte(1'b1, req.char_code, 8'd0);
        endcase
        final_evt = expected_events.pop_back();
        final_evt.last = 1'b1;
        expected_events.push_back(final_evt);
    endtask

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_lcd_evt want;
        if (!i_rst_n) begin
            expected_events.delete();
            enable_pulse_ms = ENABLE_PULSE_RST;
            poweron_wait_ms = POWERON_WAIT_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE_PULSE: enable_pulse_ms = i_cfg_data[3:0];
                    CFG_POWERON_WAIT: poweron_wait_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                queue_bus_events(i_req);
            end
            if (i_evt_valid && i_evt_ready) begin
                if (expected_events.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected event, expected none, actual %h", $time, i_evt);
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", 8'(want.event_kind), 8'(i_evt.event_kind));
                    check_field("reg_select", 8'(want.reg_select), 8'(i_evt.reg_select));
                    check_field("nibble", 8'(want.nibble), 8'(i_evt.nibble));
                    check_field("wait_ms", want.wait_ms, i_evt.wait_ms);
                    check_field("last", 8'(want.last), 8'(i_evt.last));
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_events.size();
    end

endmodule

// ----- sim/tb_char_lcd_4bit_sequencer.sv -----
// Top of the char_lcd_4bit_sequencer testbench: clock, reset, request stimulus,
// register writes, receiver stalls and the verdict. Depends on clcd_pkg, the
// sequencer RTL and lcd_bus_event_checker.
module tb_char_lcd_4bit_sequencer;
    timeunit 1ns;
    timeprecision 1ps;
    import clcd_pkg::*;

    localparam logic [1:0] CFG_SPARE_LO     = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI     = 2'd3;
    localparam int         RANDOM_PER_PHASE = 84;
    localparam int         BURST_UNDER_HOLD = 30;
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam int         DRAIN_CYCLES     = 20;
    localparam int         WATCHDOG_LIMIT   = 2000;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic       o_ready;
    t_lcd_req   i_req      = '0;
    logic       o_valid;
    logic       i_ready    = 1'b0;
    t_lcd_evt   o_evt;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_idx  = CFG_ENABLE_PULSE;
    logic [7:0] i_cfg_data = 8'd0;

    int unsigned mismatch_count;
    int unsigned pending_events;
    int unsigned idle_cycles   = 0;
    int unsigned hold_off_seq  = 0;
    int unsigned hold_off_seen = 0;
    int unsigned hold_left     = 0;
    int unsigned mode_left     = 0;
    t_rx_mode    rx_mode       = RX_STREAM;

    char_lcd_4bit_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_evt      (o_evt),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    lcd_bus_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_req        (i_req),
        .i_evt_valid  (o_valid),
        .i_evt_ready  (i_ready),
        .i_evt        (o_evt),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_events)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Event receiver. A change of hold_off_seq starts a long hold-off; otherwise
    // the stall pattern switches to a randomly chosen mode whenever mode_left runs out.
    always @(posedge i_clk) begin
        if (hold_off_seq != hold_off_seen) begin
            hold_off_seen <= hold_off_seq;
            hold_left     <= LONG_HOLD_CYCLES;
            i_ready       <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 96);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_STREAM:   i_ready <= 1'b1;
                RX_COIN:     i_ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: i_ready <= (mode_left[1:0] == 2'd0);
                default:     i_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Ends the run if no transfer happens on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("char_lcd_4bit_sequencer verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_lcd_req make_req(input t_op op, input logic [7:0] ch,
                                          input logic [5:0] col, input logic [2:0] row);
        t_lcd_req req;
        req.opcode     = op;
        req.char_code  = ch;
        req.column     = col;
        req.line_index = row;
        return req;
    endfunction

    // Unused fields stay random so that they are shown to be ignored.
    function automatic t_lcd_req random_req();
        t_lcd_req    req;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            req.opcode = OP_INIT;
        end else if (pick < 34) begin
            req.opcode = OP_CLEAR;
        end else if (pick < 67) begin
            req.opcode = OP_MOVE;
        end else begin
            req.opcode = OP_WRITE;
        end
        req.char_code  = 8'($urandom);
        req.column     = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63))
                                                     : 6'($urandom_range(0, 39));
        req.line_index = 3'($urandom_range(0, 7));
        return req;
    endfunction

    // Returns at the edge where the request transfer happens, with valid still high.
    task automatic send_req(input t_lcd_req req);
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_req(random_req());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values; every operation, row saturation, column
        // beyond the display and the field extremes.
        send_req(make_req(OP_INIT, 8'h00, 6'd0, 3'd0));
        send_req(make_req(OP_CLEAR, 8'hFF, 6'd63, 3'd7));
        send_req(make_req(OP_MOVE, 8'h00, 6'd0, 3'd0));
        send_req(make_req(OP_MOVE, 8'h00, 6'd39, 3'd1));
        send_req(make_req(OP_MOVE, 8'h00, 6'd21, 3'd2));
        send_req(make_req(OP_MOVE, 8'h00, 6'd39, 3'd3));
        send_req(make_req(OP_MOVE, 8'h00, 6'd0, 3'd4));
        send_req(make_req(OP_MOVE, 8'h00, 6'd42, 3'd5));
        send_req(make_req(OP_MOVE, 8'h00, 6'd63, 3'd7));
        send_req(make_req(OP_WRITE, 8'h00, 6'd0, 3'd0));
        send_req(make_req(OP_WRITE, 8'hFF, 6'd0, 3'd0));
        send_req(make_req(OP_WRITE, 8'h55, 6'd0, 3'd0));
        send_req(make_req(OP_WRITE, 8'hAA, 6'd0, 3'd0));
        send_req(make_req(OP_INIT, 8'hFF, 6'd63, 3'd7));
        run_random(RANDOM_PER_PHASE);
        settle();

        // Largest settings. The receiver holds off while requests keep coming.
        write_reg(CFG_ENABLE_PULSE, 8'd15);
        write_reg(CFG_POWERON_WAIT, 8'd255);
        write_reg(CFG_SPARE_LO, 8'($urandom));
        send_req(make_req(OP_INIT, 8'h00, 6'd0, 3'd0));
        hold_off_seq <= hold_off_seq + 1;
        for (int k = 0; k < BURST_UNDER_HOLD; k++) begin
            send_req(random_req());
        end
        run_random(RANDOM_PER_PHASE);
        settle();

        // Smallest settings, with a pause in the middle until all events are out.
        write_reg(CFG_ENABLE_PULSE, 8'd1);
        write_reg(CFG_POWERON_WAIT, 8'd0);
        write_reg(CFG_SPARE_HI, 8'($urandom));
        run_random(RANDOM_PER_PHASE / 2);
        settle();
        send_req(make_req(OP_INIT, 8'h00, 6'd0, 3'd0));
        run_random(RANDOM_PER_PHASE / 2);
        settle();

        // Data wider than the pulse register: the checker copy keeps only the low four bits.
        write_reg(CFG_ENABLE_PULSE, 8'hF0);
        write_reg(CFG_POWERON_WAIT, 8'($urandom));
        run_random(RANDOM_PER_PHASE);
        settle();

        write_reg(CFG_ENABLE_PULSE, 8'($urandom));
        write_reg(CFG_POWERON_WAIT, 8'd128);
        run_random(RANDOM_PER_PHASE);
        settle();

        if (mismatch_count == 0 && pending_events == 0) begin
            $display("char_lcd_4bit_sequencer verification clean");
        end else begin
            $display("char_lcd_4bit_sequencer verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/clcd_pkg.sv
rtl/clcd_front.sv
rtl/clcd_queue.sv
rtl/clcd_back.sv
rtl/char_lcd_4bit_sequencer.sv
sim/lcd_bus_event_checker.sv
sim/tb_char_lcd_4bit_sequencer.sv
